/* sv/cic_decimator_top_assert.svh */
// ----------------------------------------------------------------------------
// CIC decimator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIC_DECIMATOR_TOP_ASSERT_SVH
`define CIC_DECIMATOR_TOP_ASSERT_SVH

// same-cycle implication
`define CIC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cic_decimator: assertion failed");

// next-cycle implication
`define CIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cic_decimator: assertion failed");

`endif

/* sv/cic_pkg.sv */
// ----------------------------------------------------------------------------
// cic_pkg
// Constants, configuration types and clamping helpers of the CIC decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package cic_pkg;

  localparam int MAX_STAGES  = 6;
  localparam int MAX_DELAY   = 4;

  localparam int DATA_W      = 32;
  localparam int DECIM_W     = 16;
  localparam int STAGE_FLD_W = 3;
  localparam int DELAY_FLD_W = 3;
  localparam int GAIN_W      = 32;

  localparam int STG_CNT_W   = $clog2(MAX_STAGES + 1);
  localparam int STG_IDX_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int DLY_CNT_W   = $clog2(MAX_DELAY + 1);
  localparam int DLY_IDX_W   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CFG_ADDR_W-1:0] REG_DECIM  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_STAGES = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN   = CFG_ADDR_W'(3);

  // configuration as used by the datapath (already clamped)
  typedef struct packed {
    logic [DECIM_W-1:0]   decim;
    logic [STG_CNT_W-1:0] nst;
    logic [DLY_CNT_W-1:0] dly;
    logic [GAIN_W-1:0]    gain;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [DECIM_W-1:0] fix_decim(input logic [DECIM_W-1:0] v);
    logic [DECIM_W-1:0] r;
    r = (v == '0) ? DECIM_W'(1) : v;
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] fix_gain(input logic [GAIN_W-1:0] v);
    logic [GAIN_W-1:0] r;
    r = (v == '0) ? GAIN_W'(1) : v;
    return r;
  endfunction

  function automatic logic [STG_CNT_W-1:0] clamp_stages(input logic [STAGE_FLD_W-1:0] v);
    logic [STG_CNT_W-1:0] r;
    if (v == '0) begin
      r = STG_CNT_W'(1);
    end else if (int'(v) > MAX_STAGES) begin
      r = STG_CNT_W'(MAX_STAGES);
    end else begin
      r = STG_CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [DLY_CNT_W-1:0] clamp_delay(input logic [DELAY_FLD_W-1:0] v);
    logic [DLY_CNT_W-1:0] r;
    if (v == '0) begin
      r = DLY_CNT_W'(1);
    end else if (int'(v) > MAX_DELAY) begin
      r = DLY_CNT_W'(MAX_DELAY);
    end else begin
      r = DLY_CNT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/cic_front.sv */
// ----------------------------------------------------------------------------
// cic_front
// Accepts samples, runs them through the integrator chain with one shared
// adder, counts the decimation phase and queues every M-th integrator value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cic_decimator_top_assert.svh"

module cic_front
  import cic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] sample,
  input  q_status_t         q_status,
  output logic              push,
  output logic [DATA_W-1:0] push_data
);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_INTEG = 3'b010,
    F_PUSH  = 3'b100
  } front_state_t;

  front_state_t         state;
  logic [STG_IDX_W-1:0] s;
  logic [DATA_W-1:0]    x;
  logic [DATA_W-1:0]    integ [MAX_STAGES];
  logic [DECIM_W-1:0]   phase;

  logic [DATA_W-1:0]    sum;
  logic [STG_CNT_W-1:0] last_idx;
  logic                 last;
  logic [DECIM_W:0]     phase_inc;
  logic                 more;

  assign sum       = integ[s] + x;
  assign last_idx  = cfg.nst - STG_CNT_W'(1);
  assign last      = (STG_CNT_W'(s) == last_idx);
  assign phase_inc = (DECIM_W + 1)'(phase) + (DECIM_W + 1)'(1);
  assign more      = (phase_inc < {1'b0, cfg.decim});

  assign in_stall  = (state != F_IDLE);
  assign push      = (state == F_PUSH) && !q_status.full;
  assign push_data = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      s     <= '0;
      phase <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        integ[i] <= '0;
      end
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            x     <= sample;
            s     <= '0;
            state <= F_INTEG;
          end
        end
        F_INTEG: begin
          integ[s] <= sum;
          x        <= sum;
          if (last) begin
            if (more) begin
              phase <= phase_inc[DECIM_W-1:0];
              state <= F_IDLE;
            end else begin
              phase <= '0;
              state <= F_PUSH;
            end
          end else begin
            s <= s + STG_IDX_W'(1);
          end
        end
        F_PUSH: begin
          if (!q_status.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `CIC_ASSERT_IMPLY(a_push_phase_clear, state == F_PUSH, phase == '0)

endmodule

`default_nettype wire

/* sv/cic_queue.sv */
// ----------------------------------------------------------------------------
// cic_queue
// Short word queue between the integrator front and the comb/divide back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cic_decimator_top_assert.svh"

module cic_queue
  import cic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output q_status_t         q_status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign pop_data       = mem[rd_ptr];
  assign q_status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      priority if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `CIC_ASSERT_IMPLY(a_no_push_full, push, !q_status.full)
  `CIC_ASSERT_IMPLY(a_no_pop_empty, pop, !q_status.empty)

endmodule

`default_nettype wire

/* sv/cic_back.sv */
// ----------------------------------------------------------------------------
// cic_back
// Runs a queued integrator word through the comb stages one stage a cycle,
// divides by the gain with a bit-serial signed divider and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cic_decimator_top_assert.svh"

module cic_back
  import cic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  q_status_t         q_status,
  output logic              pop,
  input  logic [DATA_W-1:0] pop_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] filtered
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_COMB = 4'b0010,
    B_DIV  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  back_state_t          state;
  logic [STG_IDX_W-1:0] s;
  logic [DATA_W-1:0]    v;
  logic [DATA_W-1:0]    line [MAX_STAGES][MAX_DELAY];
  logic                 neg;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quot;
  logic [DIV_CNT_W-1:0] cnt;

  logic [DLY_CNT_W-1:0] dly_m1;
  logic [DLY_IDX_W-1:0] tap;
  logic [STG_CNT_W-1:0] last_idx;
  logic                 last;
  logic [DATA_W-1:0]    cdiff;
  logic [DATA_W-1:0]    mag;
  logic [DATA_W:0]      shifted;
  logic [DATA_W+1:0]    trial;
  logic                 ge;
  logic [DATA_W-1:0]    result;

  assign dly_m1   = cfg.dly - DLY_CNT_W'(1);
  assign tap      = dly_m1[DLY_IDX_W-1:0];
  assign last_idx = cfg.nst - STG_CNT_W'(1);
  assign last     = (STG_CNT_W'(s) == last_idx);
  assign cdiff    = v - line[s][tap];
  assign mag      = cdiff[DATA_W-1] ? (~cdiff + DATA_W'(1)) : cdiff;

  // restoring step: shift in next dividend bit, subtract gain if it fits
  assign shifted  = {rem, quot[DATA_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, cfg.gain};
  assign ge       = !trial[DATA_W+1];
  assign result   = neg ? (~quot + DATA_W'(1)) : quot;

  assign pop      = (state == B_IDLE) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      s         <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        for (int k = 0; k < MAX_DELAY; k++) begin
          line[i][k] <= '0;
        end
      end
    end else begin
      if (out_valid && !out_stall && (state != B_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_status.empty) begin
            v     <= pop_data;
            s     <= '0;
            state <= B_COMB;
          end
        end
        B_COMB: begin
          line[s][0] <= v;
          for (int k = 1; k < MAX_DELAY; k++) begin
            line[s][k] <= line[s][k-1];
          end
          v <= cdiff;
          if (last) begin
            neg   <= cdiff[DATA_W-1];
            quot  <= mag;
            rem   <= '0;
            cnt   <= '0;
            state <= B_DIV;
          end else begin
            s <= s + STG_IDX_W'(1);
          end
        end
        B_DIV: begin
          rem  <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
          quot <= {quot[DATA_W-2:0], ge};
          cnt  <= cnt + DIV_CNT_W'(1);
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid || !out_stall) begin
            filtered  <= result;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `CIC_ASSERT_NEXT(a_pop_starts_comb, pop, (state == B_COMB) && (s == '0))
  `CIC_ASSERT_IMPLY(a_quot_bound, state == B_OUT, quot <= 32'h8000_0000)

endmodule

`default_nettype wire

/* sv/cic_decimator_top.sv */
// ----------------------------------------------------------------------------
// cic_decimator_top
// Hogenauer CIC decimation filter on signed 32-bit samples.
// ----------------------------------------------------------------------------
// Each sample goes through N wrapping integrators on one shared adder, so the
// input side stalls while it integrates a sample and, on a sample that
// produces an output, while it pushes that value into the two-word queue,
// waiting while the queue is full. Every M-th integrator value is queued to
// the back end, which pops a word, runs the N comb stages one a cycle, then a
// 32-step bit-serial signed divider, and loads the output register once it is
// empty or its result is taken. The front keeps taking samples while the back
// works and while a result waits in the output register, until the queue
// fills. Registers are written through cfg_wen/cfg_addr/cfg_wdata; values
// out of range are clamped at the write. Reset clears control, configuration,
// integrator, comb-line and queue-pointer state, but not the data registers.
`default_nettype none

module cic_decimator_top
  import cic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     filtered
);

  cfg_t              cfg;
  q_status_t         q_status;
  logic              push;
  logic [DATA_W-1:0] push_data;
  logic              pop;
  logic [DATA_W-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decim <= DECIM_W'(1);
      cfg.nst   <= STG_CNT_W'(1);
      cfg.dly   <= DLY_CNT_W'(1);
      cfg.gain  <= GAIN_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_DECIM:  cfg.decim <= fix_decim(cfg_wdata[DECIM_W-1:0]);
        REG_STAGES: cfg.nst   <= clamp_stages(cfg_wdata[STAGE_FLD_W-1:0]);
        REG_DELAY:  cfg.dly   <= clamp_delay(cfg_wdata[DELAY_FLD_W-1:0]);
        REG_GAIN:   cfg.gain  <= fix_gain(cfg_wdata[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  cic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  cic_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  cic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered)
  );

endmodule

`default_nettype wire

/* verif/tb_cic_decimator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cic_decimator_top
// Self-checking bench for the CIC decimator. A directed plan covers sample
// extremes, register clamping, gain rounding and mid-stream register changes.
// Random phases with fresh register settings follow. Every accepted word is
// run through a local integrator/comb/divide model, and each output word is
// compared in order against it, or against the plan's expected word on rows
// that give one. Sender bursts and receiver stalls vary throughout the run.
// ----------------------------------------------------------------------------

module tb_cic_decimator_top;
  import cic_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int SETTLE_CYC   = 64;
  localparam int RANDOM_WORDS = 425;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;
  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           val;
    logic                  typed;
    logic [31:0]           want;
  } plan_row_t;

  localparam plan_row_t PLAN [0:42] = '{
    '{ROW_WORD, REG_DECIM,  32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_WORD, REG_DECIM,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ROW_WORD, REG_DECIM,  32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_WORD, REG_DECIM,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_WORD, REG_DECIM,  32'h0000_0001, 1'b1, 32'h0000_0001},
    '{ROW_REG,  REG_GAIN,   32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h1234_5678, 1'b1, 32'h1234_5678},
    '{ROW_REG,  REG_GAIN,   32'h0000_0002, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFF},
    '{ROW_WORD, REG_DECIM,  32'h0000_0003, 1'b1, 32'h0000_0001},
    '{ROW_REG,  REG_GAIN,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h8000_0000, 1'b1, 32'h0000_0000},
    '{ROW_REG,  REG_GAIN,   32'h0000_0001, 1'b0, 32'h0},
    '{ROW_REG,  REG_STAGES, 32'h0000_0007, 1'b0, 32'h0},
    '{ROW_REG,  REG_DELAY,  32'h0000_0007, 1'b0, 32'h0},
    '{ROW_REG,  REG_DECIM,  32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h8000_0000, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h5555_5555, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'hAAAA_AAAA, 1'b0, 32'h0},
    '{ROW_REG,  REG_DECIM,  32'h0000_FFFF, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_0100, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'hFFFF_FF00, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_FFFF, 1'b0, 32'h0},
    // ratio lowered below the running phase: next word emits
    '{ROW_REG,  REG_DECIM,  32'h0000_0002, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_0007, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_0011, 1'b0, 32'h0},
    '{ROW_REG,  REG_STAGES, 32'h0000_0002, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_1000, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_2000, 1'b0, 32'h0},
    '{ROW_REG,  REG_STAGES, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REG,  REG_DELAY,  32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_0042, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'hFFFF_FFC0, 1'b0, 32'h0},
    // stages beyond the short setting kept their old contents
    '{ROW_REG,  REG_STAGES, 32'h0000_0006, 1'b0, 32'h0},
    '{ROW_REG,  REG_DELAY,  32'h0000_0003, 1'b0, 32'h0},
    '{ROW_REG,  REG_DECIM,  32'h0000_0001, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_000F, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h8000_0001, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h7FFF_FFFE, 1'b0, 32'h0},
    '{ROW_REG,  REG_GAIN,   32'h0001_0000, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WORD, REG_DECIM,  32'h0123_4567, 1'b0, 32'h0}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wen   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic [DATA_W-1:0]     sample    = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [DATA_W-1:0]     filtered;

  cic_decimator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered)
  );

  always #6 clk = ~clk;

  // filter model state
  logic [15:0] decim_reg;
  logic [2:0]  stages_reg;
  logic [2:0]  delay_reg;
  logic [31:0] gain_reg;
  logic [31:0] integ [MAX_STAGES];
  logic [31:0] comb_hist [MAX_STAGES][MAX_DELAY];
  logic [15:0] phase;

  logic [31:0] filtered_due [$];
  int          err_count    = 0;
  int          cycle_count  = 0;
  int          burst_left   = 0;
  rx_mode_t    rx_mode      = RX_FREE;
  int          rx_left      = 0;

  function automatic bit decimate_sample(input logic [31:0] x_in, output logic [31:0] q_out);
    int          n_st;
    int          r;
    logic [31:0] m;
    logic [31:0] x;
    logic [31:0] v;
    logic [31:0] old;
    longint      num;
    longint      den;
    longint      quo;
    n_st = (stages_reg == 0) ? 1 : ((stages_reg > MAX_STAGES) ? MAX_STAGES : int'(stages_reg));
    r    = (delay_reg == 0) ? 1 : ((delay_reg > MAX_DELAY) ? MAX_DELAY : int'(delay_reg));
    m    = (decim_reg == 0) ? 32'd1 : {16'd0, decim_reg};
    x    = x_in;
    q_out = '0;
    for (int s = 0; s < n_st; s++) begin
      integ[s] = integ[s] + x;
      x = integ[s];
    end
    if ({16'd0, phase} + 32'd1 < m) begin
      phase = phase + 16'd1;
      return 1'b0;
    end
    phase = '0;
    v = integ[n_st-1];
    for (int s = 0; s < n_st; s++) begin
      old = comb_hist[s][r-1];
      for (int k = MAX_DELAY - 1; k > 0; k--) comb_hist[s][k] = comb_hist[s][k-1];
      comb_hist[s][0] = v;
      v = v - old;
    end
    num = $signed(v);
    den = (gain_reg == 0) ? 64'd1 : {32'd0, gain_reg};
    quo = num / den;
    q_out = quo[31:0];
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      REG_DECIM:  decim_reg  = data[15:0];
      REG_STAGES: stages_reg = data[2:0];
      REG_DELAY:  delay_reg  = data[2:0];
      REG_GAIN:   gain_reg   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic send_word(input logic [31:0] x, input bit typed, input logic [31:0] want);
    logic [31:0] q;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        sample   <= $urandom;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= x;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (decimate_sample(x, q)) filtered_due.push_back(typed ? want : q);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(40, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default:   out_stall <= ((cycle_count % 37) < 15);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (filtered_due.size() == 0) begin
        $error("filtered: expected none, actual %h", filtered);
        err_count++;
      end else begin
        logic [31:0] exp_word;
        exp_word = filtered_due.pop_front();
        if (filtered !== exp_word) begin
          $error("filtered: expected %h, actual %h", exp_word, filtered);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int          rand_words;
    int          len;
    int          pause_at;
    logic [31:0] pick;
    logic [31:0] x;
    decim_reg  = 16'd1;
    stages_reg = 3'd1;
    delay_reg  = 3'd1;
    gain_reg   = 32'd1;
    phase      = '0;
    for (int s = 0; s < MAX_STAGES; s++) begin
      integ[s] = '0;
      for (int k = 0; k < MAX_DELAY; k++) comb_hist[s][k] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_REG) begin
        settle();
        write_reg(PLAN[i].addr, PLAN[i].val);
      end else begin
        send_word(PLAN[i].val, PLAN[i].typed, PLAN[i].want);
      end
    end

    rand_words = 0;
    while (rand_words < RANDOM_WORDS) begin
      settle();
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       pick = 32'd0;
          1:       pick = $urandom_range(5, 16);
          default: pick = $urandom_range(1, 4);
        endcase
        write_reg(REG_DECIM, ($urandom & 32'hFFFF_0000) | pick);
      end
      if ($urandom_range(0, 1))
        write_reg(REG_STAGES, ($urandom & 32'hFFFF_FFF8) | $urandom_range(0, 7));
      if ($urandom_range(0, 1))
        write_reg(REG_DELAY, ($urandom & 32'hFFFF_FFF8) | $urandom_range(0, 7));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0:       pick = 32'd0;
          1:       pick = 32'd1;
          2:       pick = $urandom_range(2, 16);
          3:       pick = 32'd1 << $urandom_range(0, 31);
          4:       pick = 32'hFFFF_FFFF;
          5:       pick = $urandom;
          default: pick = $urandom_range(1, 1000);
        endcase
        write_reg(REG_GAIN, pick);
      end
      len      = $urandom_range(10, 50);
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : -1;
      for (int k = 0; k < len && rand_words < RANDOM_WORDS; k++) begin
        if (k == pause_at) hold_until_drained();
        case ($urandom_range(0, 9))
          0:       x = 32'h7FFF_FFFF;
          1:       x = 32'h8000_0000;
          2:       x = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
          3, 4:    x = $urandom_range(0, 511) - 256;
          default: x = $urandom;
        endcase
        send_word(x, 1'b0, 32'd0);
        rand_words++;
      end
    end

    hold_until_drained();
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
